// ===== rtl/ksq_pkg.sv =====
package ksq_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 8;

    // rotation coefficients, Q1.14
    localparam int ROT_W    = 16;
    localparam int ROT_FRAC = 14;

    localparam int SIZE_W    = 10;
    localparam int CFG_IDX_W = 3;

    // quotient bits consumed per remainder stage
    localparam int REM_STEPS = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X      = 3'd0,
        CFG_CENTER_Y      = 3'd1,
        CFG_SQUARE_SIZE   = 3'd2,
        CFG_COS_ROTATION  = 3'd3,
        CFG_SIN_ROTATION  = 3'd4,
        CFG_BUFFER_WIDTH  = 3'd5,
        CFG_BUFFER_HEIGHT = 3'd6
    } t_cfg_idx;

    // restoring remainder, REM_STEPS dividend bits MSB first; rem < size on entry
    function automatic logic [SIZE_W-1:0] rem_step(
        input logic [SIZE_W-1:0]    rem,
        input logic [REM_STEPS-1:0] bits,
        input logic [SIZE_W-1:0]    size
    );
        logic [SIZE_W:0]   acc;
        logic [SIZE_W-1:0] r;
        r = rem;
        for (int i = REM_STEPS - 1; i >= 0; i--) begin
            acc = {r, bits[i]};
            if (acc >= {1'b0, size}) begin
                acc = acc - {1'b0, size};
            end
            r = acc[SIZE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/ksq_ifs.sv =====
interface ksq_pix_if #(
    parameter int COORD_BITS = ksq_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface ksq_src_if #(
    parameter int COORD_BITS = ksq_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] source_x;
    logic [COORD_BITS-1:0] source_y;
    logic                  copy_pixel;

    modport source (output valid, output source_x, output source_y, output copy_pixel,
                    input ready);
    modport sink   (input valid, input source_x, input source_y, input copy_pixel,
                    output ready);
endinterface

// ===== rtl/kaleidoscope_square_fold_core.sv =====
// Throughput: one word per cycle while o_src is not stalled; the depth is set by the remainder
// modulo the square size, which takes four quotient bits per stage.
// Each stage holds its word under backpressure and fills independently of later stages.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
module kaleidoscope_square_fold_core #(
    parameter int COORD_BITS = ksq_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = ksq_pkg::FRAC_BITS_DEF,
    localparam int CFG_W = (COORD_BITS + 1 > ksq_pkg::ROT_W) ? COORD_BITS + 1 : ksq_pkg::ROT_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ksq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data,
    ksq_pix_if.sink                       i_pix,
    ksq_src_if.source                     o_src
);
    localparam int C    = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int RW   = ksq_pkg::ROT_W;
    localparam int RF   = ksq_pkg::ROT_FRAC;
    localparam int SZW  = ksq_pkg::SIZE_W;
    localparam int STEP = ksq_pkg::REM_STEPS;

    localparam int DW  = C + 1;          // centre offset
    localparam int PW  = DW + RW;        // forward product
    localparam int SW  = PW + 1;         // forward sum, Q14
    localparam int TFW = SW + F;
    localparam int LW  = TFW - RF;       // local coordinate at F fraction bits
    localparam int UW  = LW + 1;
    localparam int QW  = UW - F - 1;     // period count
    localparam int NRS = (QW + STEP - 1) / STEP;
    localparam int MW  = NRS * STEP;
    localparam int TW  = SZW + F + 1;    // phase within period
    localparam int FW  = TW + 1;         // folded value
    localparam int BPW = FW + RW;        // back product
    localparam int K   = F + RF;
    localparam int WA  = (BPW + 1 > C + K + 1) ? BPW + 1 : C + K + 1;
    localparam int WW  = WA + 1;
    localparam int SXW = WW - K;
    localparam int CMW = (SXW > C + 2) ? SXW : C + 2;

    localparam int ST_MUL   = 0;
    localparam int ST_LOC   = 1;
    localparam int ST_SPLIT = 2;
    localparam int ST_FOLD  = 3 + NRS;
    localparam int ST_BMUL  = 4 + NRS;
    localparam int ST_SUM   = 5 + NRS;
    localparam int ST_OUT   = 6 + NRS;
    localparam int N        = 7 + NRS;

    localparam logic signed [TFW-1:0] RND_Q14 = TFW'(1) << (RF - 1);
    localparam logic signed [WW-1:0]  HALF_K  = WW'(1) << (K - 1);
    localparam logic [C:0]            BUF_RST = (C + 1)'(1) << C;

    // configuration
    logic        [C-1:0]   r_center_x, r_center_y;
    logic        [SZW-1:0] r_size;
    logic signed [RW-1:0]  r_cos, r_sin;
    logic        [C:0]     r_buf_w, r_buf_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_size     <= SZW'(5);
            r_cos      <= RW'(16384);
            r_sin      <= '0;
            r_buf_w    <= BUF_RST;
            r_buf_h    <= BUF_RST;
        end else if (i_cfg_we) begin
            unique case (ksq_pkg::t_cfg_idx'(i_cfg_idx))
                ksq_pkg::CFG_CENTER_X:      r_center_x <= i_cfg_data[C-1:0];
                ksq_pkg::CFG_CENTER_Y:      r_center_y <= i_cfg_data[C-1:0];
                ksq_pkg::CFG_SQUARE_SIZE:   r_size     <= i_cfg_data[SZW-1:0];
                ksq_pkg::CFG_COS_ROTATION:  r_cos      <= $signed(i_cfg_data[RW-1:0]);
                ksq_pkg::CFG_SIN_ROTATION:  r_sin      <= $signed(i_cfg_data[RW-1:0]);
                ksq_pkg::CFG_BUFFER_WIDTH:  r_buf_w    <= i_cfg_data[C:0];
                ksq_pkg::CFG_BUFFER_HEIGHT: r_buf_h    <= i_cfg_data[C:0];
                default: ;
            endcase
        end
    end

    logic [SZW-1:0] size_eff;
    assign size_eff = (r_size == '0) ? SZW'(1) : r_size;

    // stage handshake: a stage loads when empty or when its word moves on
    logic [N-1:0] r_v;
    logic [N-1:0] en;

    always_comb begin
        en[N-1] = !r_v[N-1] || o_src.ready;
        for (int i = N - 2; i >= 0; i--) begin
            en[i] = !r_v[i] || en[i+1];
        end
    end

    assign i_pix.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_pix.valid;
            end
            for (int i = 1; i < N; i++) begin
                if (en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // destination pixel travels alongside for the final compare
    logic [C-1:0] r_px [N-1];
    logic [C-1:0] r_py [N-1];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_px[0] <= i_pix.pixel_x;
            r_py[0] <= i_pix.pixel_y;
        end
        for (int i = 1; i < N - 1; i++) begin
            if (en[i]) begin
                r_px[i] <= r_px[i-1];
                r_py[i] <= r_py[i-1];
            end
        end
    end

    // forward rotation products
    logic signed [DW-1:0] dx, dy;
    logic signed [PW-1:0] r_p_xc, r_p_ys, r_p_yc, r_p_xs;

    assign dx = $signed({1'b0, i_pix.pixel_x}) - $signed({1'b0, r_center_x});
    assign dy = $signed({1'b0, i_pix.pixel_y}) - $signed({1'b0, r_center_y});

    always_ff @(posedge i_clk) begin
        if (en[ST_MUL]) begin
            r_p_xc <= PW'(dx) * PW'(r_cos);
            r_p_ys <= PW'(dy) * PW'(r_sin);
            r_p_yc <= PW'(dy) * PW'(r_cos);
            r_p_xs <= PW'(dx) * PW'(r_sin);
        end
    end

    // sum and Q14 to F fraction bits, rounding half up
    logic signed [SW-1:0]  sum_x, sum_y;
    logic signed [TFW-1:0] sc_x, sc_y, sh_x, sh_y;
    logic signed [LW-1:0]  r_lx, r_ly;

    always_comb begin
        sum_x = SW'(r_p_xc) + SW'(r_p_ys);
        sum_y = SW'(r_p_yc) - SW'(r_p_xs);
        sc_x  = (TFW'(sum_x) <<< F) + RND_Q14;
        sc_y  = (TFW'(sum_y) <<< F) + RND_Q14;
        sh_x  = sc_x >>> RF;
        sh_y  = sc_y >>> RF;
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_LOC]) begin
            r_lx <= sh_x[LW-1:0];
            r_ly <= sh_y[LW-1:0];
        end
    end

    // shift by half a size; split into period count (sign and magnitude) and low bits
    logic        [UW-1:0] h_u;
    logic signed [UW-1:0] u_x, u_y, q_x, q_y;
    logic        [QW-1:0] mag_x, mag_y;

    always_comb begin
        h_u   = UW'(size_eff) << (F - 1);
        u_x   = UW'(r_lx) + $signed(h_u);
        u_y   = UW'(r_ly) + $signed(h_u);
        q_x   = u_x >>> (F + 1);
        q_y   = u_y >>> (F + 1);
        mag_x = u_x[UW-1] ? QW'(~q_x[QW-1:0] + QW'(1)) : q_x[QW-1:0];
        mag_y = u_y[UW-1] ? QW'(~q_y[QW-1:0] + QW'(1)) : q_y[QW-1:0];
    end

    // index 0 is the split stage, index j the j-th remainder stage
    logic [SZW-1:0] r_rem_x [NRS+1];
    logic [SZW-1:0] r_rem_y [NRS+1];
    logic [MW-1:0]  r_mag_x [NRS+1];
    logic [MW-1:0]  r_mag_y [NRS+1];
    logic           r_neg_x [NRS+1];
    logic           r_neg_y [NRS+1];
    logic [F:0]     r_low_x [NRS+1];
    logic [F:0]     r_low_y [NRS+1];

    always_ff @(posedge i_clk) begin
        if (en[ST_SPLIT]) begin
            r_rem_x[0] <= '0;
            r_rem_y[0] <= '0;
            r_mag_x[0] <= MW'(mag_x);
            r_mag_y[0] <= MW'(mag_y);
            r_neg_x[0] <= u_x[UW-1];
            r_neg_y[0] <= u_y[UW-1];
            r_low_x[0] <= u_x[F:0];
            r_low_y[0] <= u_y[F:0];
        end
        for (int j = 1; j <= NRS; j++) begin
            if (en[ST_SPLIT+j]) begin
                r_rem_x[j] <= ksq_pkg::rem_step(r_rem_x[j-1], r_mag_x[j-1][MW-1 -: STEP],
                                                size_eff);
                r_rem_y[j] <= ksq_pkg::rem_step(r_rem_y[j-1], r_mag_y[j-1][MW-1 -: STEP],
                                                size_eff);
                r_mag_x[j] <= r_mag_x[j-1] << STEP;
                r_mag_y[j] <= r_mag_y[j-1] << STEP;
                r_neg_x[j] <= r_neg_x[j-1];
                r_neg_y[j] <= r_neg_y[j-1];
                r_low_x[j] <= r_low_x[j-1];
                r_low_y[j] <= r_low_y[j-1];
            end
        end
    end

    // triangle fold of the phase into [-h, +h]
    logic        [SZW-1:0] rf_x, rf_y;
    logic        [TW-1:0]  t_x, t_y, h_t, h2_t, h3_t;
    logic signed [FW-1:0]  f_x, f_y;
    logic signed [FW-1:0]  r_fx, r_fy;

    always_comb begin
        // floor modulo: a negative count with a remainder wraps to size - rem
        rf_x = (r_neg_x[NRS] && r_rem_x[NRS] != '0) ? size_eff - r_rem_x[NRS] : r_rem_x[NRS];
        rf_y = (r_neg_y[NRS] && r_rem_y[NRS] != '0) ? size_eff - r_rem_y[NRS] : r_rem_y[NRS];
        t_x  = {rf_x, r_low_x[NRS]};
        t_y  = {rf_y, r_low_y[NRS]};
        h_t  = TW'(size_eff) << (F - 1);
        h2_t = TW'(size_eff) << F;
        h3_t = h2_t + h_t;
        f_x  = (t_x <= h2_t) ? $signed(FW'(t_x)) - $signed(FW'(h_t))
                             : $signed(FW'(h3_t)) - $signed(FW'(t_x));
        f_y  = (t_y <= h2_t) ? $signed(FW'(t_y)) - $signed(FW'(h_t))
                             : $signed(FW'(h3_t)) - $signed(FW'(t_y));
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_FOLD]) begin
            r_fx <= f_x;
            r_fy <= f_y;
        end
    end

    // back rotation
    logic signed [BPW-1:0] r_b_xc, r_b_ys, r_b_xs, r_b_yc;

    always_ff @(posedge i_clk) begin
        if (en[ST_BMUL]) begin
            r_b_xc <= BPW'(r_fx) * BPW'(r_cos);
            r_b_ys <= BPW'(r_fy) * BPW'(r_sin);
            r_b_xs <= BPW'(r_fx) * BPW'(r_sin);
            r_b_yc <= BPW'(r_fy) * BPW'(r_cos);
        end
    end

    logic        [WW-1:0] cx_u, cy_u;
    logic signed [WW-1:0] w_x, w_y;
    logic signed [WW-1:0] r_wx, r_wy;

    always_comb begin
        cx_u = WW'(r_center_x) << K;
        cy_u = WW'(r_center_y) << K;
        w_x  = WW'(r_b_xc) - WW'(r_b_ys) + $signed(cx_u);
        w_y  = WW'(r_b_xs) + WW'(r_b_yc) + $signed(cy_u);
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_SUM]) begin
            r_wx <= w_x;
            r_wy <= w_y;
        end
    end

    // round half away from zero, then bounds and identity check
    logic signed [WW-1:0]  a_x, a_y, s_x, s_y;
    logic signed [CMW-1:0] sx, sy, bw_s, bh_s, lim_s, px_s, py_s;
    logic                  copy;
    logic        [C-1:0]   r_sx, r_sy;
    logic                  r_copy;

    always_comb begin
        a_x   = r_wx + (r_wx[WW-1] ? HALF_K - WW'(1) : HALF_K);
        a_y   = r_wy + (r_wy[WW-1] ? HALF_K - WW'(1) : HALF_K);
        s_x   = a_x >>> K;
        s_y   = a_y >>> K;
        sx    = CMW'(s_x[SXW-1:0]);
        sy    = CMW'(s_y[SXW-1:0]);
        bw_s  = $signed(CMW'(r_buf_w));
        bh_s  = $signed(CMW'(r_buf_h));
        lim_s = $signed(CMW'(1) << C);
        px_s  = $signed(CMW'(r_px[N-2]));
        py_s  = $signed(CMW'(r_py[N-2]));
        copy  = !sx[CMW-1] && !sy[CMW-1] && (sx < bw_s) && (sy < bh_s) &&
                (sx < lim_s) && (sy < lim_s) && ((sx != px_s) || (sy != py_s));
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_sx   <= copy ? sx[C-1:0] : '0;
            r_sy   <= copy ? sy[C-1:0] : '0;
            r_copy <= copy;
        end
    end

    assign o_src.valid      = r_v[N-1];
    assign o_src.source_x   = r_sx;
    assign o_src.source_y   = r_sy;
    assign o_src.copy_pixel = r_copy;

endmodule
